// ===== hdl/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, key codes, register indexes and width helpers for the servo
// pose sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Pose store geometry
  localparam int POSE_SLOTS = 4;
  localparam int SLOT_W     = $clog2(POSE_SLOTS);
  localparam int TOTAL_W    = $clog2(POSE_SLOTS + 1);

  localparam int DUTY_W = 15;
  localparam int STEP_W = 10;
  localparam int KEY_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRIP_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRIP_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_STEP = 3'd4;

  // Register reset values
  localparam logic [DUTY_W-1:0] DUTY_MIN_RST  = 15'd200;
  localparam logic [DUTY_W-1:0] DUTY_MAX_RST  = 15'd900;
  localparam logic [DUTY_W-1:0] GRIP_MIN_RST  = 15'd200;
  localparam logic [DUTY_W-1:0] GRIP_MAX_RST  = 15'd900;
  localparam logic [STEP_W-1:0] DUTY_STEP_RST = 10'd50;

  // Key codes
  localparam logic [KEY_W-1:0] K_WR_UP    = 16'hF603;
  localparam logic [KEY_W-1:0] K_WR_DN    = 16'hF600;
  localparam logic [KEY_W-1:0] K_EL_UP    = 16'hF602;
  localparam logic [KEY_W-1:0] K_EL_DN    = 16'hF601;
  localparam logic [KEY_W-1:0] K_SLOT0    = 16'hF031;
  localparam logic [KEY_W-1:0] K_ESC      = 16'hF01B;
  localparam logic [KEY_W-1:0] K_ENTER    = 16'hF201;
  localparam logic [KEY_W-1:0] K_GR_CLOSE = 16'hFB67;
  localparam logic [KEY_W-1:0] K_GR_OPEN  = 16'hFB68;

  // Request kinds
  localparam logic REQ_KEY  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Tick rearm codes
  localparam logic [1:0] WAIT_NONE  = 2'd0;
  localparam logic [1:0] WAIT_SHORT = 2'd1;
  localparam logic [1:0] WAIT_LONG  = 2'd2;
  localparam logic [1:0] WAIT_NOW   = 2'd3;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key_value;
    logic             key_pressed;
    logic             shift_active;
  } req_t;

  typedef struct packed {
    logic [DUTY_W-1:0] wrist_duty;
    logic [DUTY_W-1:0] elbow_duty;
    logic [DUTY_W-1:0] grip_duty;
    logic              playing;
    logic [1:0]        stage_now;
    logic [2:0]        saved_count;
    logic              start_rejected;
    logic [1:0]        next_wait;
  } rsp_t;

  typedef struct packed {
    logic [DUTY_W-1:0] wrist;
    logic [DUTY_W-1:0] elbow;
    logic [DUTY_W-1:0] grip;
  } pose_t;

  // Add a step, limit at hi
  function automatic logic [DUTY_W-1:0] up_clamp(input logic [DUTY_W-1:0] v,
                                                 input logic [STEP_W-1:0] step,
                                                 input logic [DUTY_W-1:0] hi);
    logic [DUTY_W:0] s;
    s = {1'b0, v} + {{(DUTY_W-STEP_W+1){1'b0}}, step};
    return (s < {1'b0, hi}) ? s[DUTY_W-1:0] : hi;
  endfunction

  // Subtract a step, limit at lo (signed compare, so underflow lands on lo)
  function automatic logic [DUTY_W-1:0] down_clamp(input logic [DUTY_W-1:0] v,
                                                   input logic [STEP_W-1:0] step,
                                                   input logic [DUTY_W-1:0] lo);
    logic signed [DUTY_W+1:0] s;
    s = $signed({2'b00, v}) - $signed({{(DUTY_W-STEP_W+2){1'b0}}, step});
    return (s > $signed({2'b00, lo})) ? s[DUTY_W-1:0] : lo;
  endfunction

  // Move one step toward g, landing exactly on it
  function automatic logic [DUTY_W-1:0] slew(input logic [DUTY_W-1:0] v,
                                             input logic [DUTY_W-1:0] g,
                                             input logic [STEP_W-1:0] step);
    logic [DUTY_W-1:0] step_x;
    logic [DUTY_W-1:0] res;
    step_x = {{(DUTY_W-STEP_W){1'b0}}, step};
    res    = v;
    if (v < g) begin
      res = ((g - v) <= step_x) ? g : v + step_x;
    end else if (v > g) begin
      res = ((v - g) <= step_x) ? g : v - step_x;
    end
    return res;
  endfunction

endpackage

// ===== hdl/sps_if.sv =====
// ----------------------------------------------------------------------------
// sps_if
// Valid/ready channels of the servo pose sequencer: request and response.
// ----------------------------------------------------------------------------
interface sps_req_if;
  logic          valid;
  logic          ready;
  sps_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sps_rsp_if;
  logic          valid;
  logic          ready;
  sps_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/servo_pose_sequencer.sv =====
// ----------------------------------------------------------------------------
// servo_pose_sequencer
// Holds wrist, elbow and grip pulse widths, handles key events and playback
// ticks, and reports the state after every request.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries key events and sequence ticks; each transfer yields exactly
//   one response transfer on rsp_o with the updated widths and status.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the limit and step registers; write
//   them only while no request is outstanding.
//   Output: each response is registered in the two-entry output buffer,
//   in its head entry or, while the head is held, in its skid entry.
//   Throughput: one request per cycle while req_i.ready is high. All
//   state updates come from combinational decode/clamp/slew logic.
//   Stall: while the receiver holds rsp_o.ready low, up to two responses are
//   buffered; req_i.ready drops only when both entries are full.
//   Reset: widths return to 200 us, limits and step to their defaults, all
//   poses are invalid, playback stopped, stage 0, output buffer empty.
// ----------------------------------------------------------------------------
module servo_pose_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sps_req_if.sink                        req_i,
  sps_rsp_if.source                      rsp_o,
  input  logic                           cfg_we_i,
  input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SW = sps_pkg::SLOT_W;
  localparam int TW = sps_pkg::TOTAL_W;
  localparam int DW = sps_pkg::DUTY_W;

  // Configuration registers
  logic [DW-1:0]               duty_min_q, duty_max_q, grip_min_q, grip_max_q;
  logic [sps_pkg::STEP_W-1:0]  duty_step_q;

  // Block state
  logic [DW-1:0]      wrist_q, wrist_d, elbow_q, elbow_d, grip_q, grip_d;
  sps_pkg::pose_t     goal_q, goal_d;
  sps_pkg::pose_t     pose_q [sps_pkg::POSE_SLOTS];
  logic [sps_pkg::POSE_SLOTS-1:0] valid_q, valid_d;
  logic [TW-1:0]      total_q, total_d;
  logic               running_q, running_d;
  logic [SW-1:0]      stage_q, stage_d;

  logic               pose_we;
  logic [SW-1:0]      pose_widx;
  logic               rejected;
  logic [1:0]         wait_code;

  // Output buffer: head entry plus skid entry
  sps_pkg::rsp_t      head_q, skid_q, res;
  logic               head_v_q, skid_v_q;
  logic               push, pop;

  sps_pkg::req_t      rq;
  logic               is_slot;
  logic [sps_pkg::KEY_W-1:0] key_off;
  logic [SW-1:0]      slot_idx;
  logic [TW-1:0]      slot_cnt;
  logic               all_valid;
  logic               start_ok;
  logic               at_goal;
  logic [TW-1:0]      stage_nxt;

  assign rq   = req_i.payload;
  assign push = req_i.valid && req_i.ready;
  assign pop  = head_v_q && rsp_o.ready;

  assign req_i.ready   = !skid_v_q;
  assign rsp_o.valid   = head_v_q;
  assign rsp_o.payload = head_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_min_q  <= sps_pkg::DUTY_MIN_RST;
      duty_max_q  <= sps_pkg::DUTY_MAX_RST;
      grip_min_q  <= sps_pkg::GRIP_MIN_RST;
      grip_max_q  <= sps_pkg::GRIP_MAX_RST;
      duty_step_q <= sps_pkg::DUTY_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sps_pkg::CFG_DUTY_MIN:  duty_min_q  <= cfg_data_i;
        sps_pkg::CFG_DUTY_MAX:  duty_max_q  <= cfg_data_i;
        sps_pkg::CFG_GRIP_MIN:  grip_min_q  <= cfg_data_i;
        sps_pkg::CFG_GRIP_MAX:  grip_max_q  <= cfg_data_i;
        sps_pkg::CFG_DUTY_STEP: duty_step_q <= cfg_data_i[sps_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Slot key decode
  assign key_off  = rq.key_value - sps_pkg::K_SLOT0;
  assign is_slot  = ({1'b0, rq.key_value} >= {1'b0, sps_pkg::K_SLOT0}) &&
                    ({1'b0, rq.key_value} <
                     ({1'b0, sps_pkg::K_SLOT0} + (sps_pkg::KEY_W+1)'(sps_pkg::POSE_SLOTS)));
  assign slot_idx = key_off[SW-1:0];
  assign slot_cnt = TW'(slot_idx) + TW'(1);

  // Start check: every slot below the total must be valid
  always_comb begin
    all_valid = 1'b1;
    for (int i = 0; i < sps_pkg::POSE_SLOTS; i++) begin
      if ((TW'(i) < total_q) && !valid_q[i]) begin
        all_valid = 1'b0;
      end
    end
  end

  assign start_ok  = (total_q >= TW'(2)) && (total_q <= TW'(sps_pkg::POSE_SLOTS)) &&
                     all_valid;
  assign at_goal   = (wrist_q == goal_q.wrist) && (elbow_q == goal_q.elbow) &&
                     (grip_q == goal_q.grip);
  assign stage_nxt = TW'(stage_q) + TW'(1);

  // Request decode and next state
  always_comb begin
    wrist_d   = wrist_q;
    elbow_d   = elbow_q;
    grip_d    = grip_q;
    goal_d    = goal_q;
    valid_d   = valid_q;
    total_d   = total_q;
    running_d = running_q;
    stage_d   = stage_q;
    pose_we   = 1'b0;
    pose_widx = slot_idx;
    rejected  = 1'b0;
    wait_code = sps_pkg::WAIT_NONE;

    if (rq.req_type == sps_pkg::REQ_KEY) begin
      if (rq.key_pressed && !rq.shift_active) begin
        if (rq.key_value == sps_pkg::K_WR_UP) begin
          wrist_d = sps_pkg::up_clamp(wrist_q, duty_step_q, duty_max_q);
        end else if (rq.key_value == sps_pkg::K_WR_DN) begin
          wrist_d = sps_pkg::down_clamp(wrist_q, duty_step_q, duty_min_q);
        end else if (rq.key_value == sps_pkg::K_EL_DN) begin
          elbow_d = sps_pkg::down_clamp(elbow_q, duty_step_q, duty_min_q);
        end else if (rq.key_value == sps_pkg::K_EL_UP) begin
          elbow_d = sps_pkg::up_clamp(elbow_q, duty_step_q, duty_max_q);
        end else if (rq.key_value == sps_pkg::K_GR_CLOSE) begin
          grip_d = sps_pkg::down_clamp(grip_q, duty_step_q, grip_min_q);
        end else if (rq.key_value == sps_pkg::K_GR_OPEN) begin
          grip_d = sps_pkg::up_clamp(grip_q, duty_step_q, grip_max_q);
        end else if (is_slot) begin
          // Save current widths into the slot
          if (total_q < slot_cnt) begin
            total_d = slot_cnt;
          end
          pose_we            = 1'b1;
          valid_d[slot_idx]  = 1'b1;
        end else if (rq.key_value == sps_pkg::K_ENTER) begin
          if (start_ok) begin
            running_d = 1'b1;
            stage_d   = '0;
            goal_d    = pose_q[0];
            wait_code = sps_pkg::WAIT_SHORT;
          end else begin
            running_d = 1'b0;
            rejected  = 1'b1;
          end
        end else if (rq.key_value == sps_pkg::K_ESC) begin
          running_d = 1'b0;
          total_d   = '0;
          valid_d   = '0;
          wait_code = sps_pkg::WAIT_NOW;
        end
      end
    end else if (running_q) begin
      if (at_goal) begin
        // Advance stage modulo the pose total (stage stays below total)
        if (total_q == '0) begin
          stage_d = '0;
        end else if (stage_nxt >= total_q) begin
          stage_d = SW'(stage_nxt - total_q);
        end else begin
          stage_d = SW'(stage_nxt);
        end
        goal_d    = pose_q[stage_d];
        wait_code = sps_pkg::WAIT_LONG;
      end else begin
        wrist_d   = sps_pkg::slew(wrist_q, goal_q.wrist, duty_step_q);
        elbow_d   = sps_pkg::slew(elbow_q, goal_q.elbow, duty_step_q);
        grip_d    = sps_pkg::slew(grip_q, goal_q.grip, duty_step_q);
        wait_code = sps_pkg::WAIT_SHORT;
      end
    end
  end

  // Response for this request
  always_comb begin
    res.wrist_duty     = wrist_d;
    res.elbow_duty     = elbow_d;
    res.grip_duty      = grip_d;
    res.playing        = running_d;
    res.stage_now      = 2'(stage_d);
    res.saved_count    = 3'(total_d);
    res.start_rejected = rejected;
    res.next_wait      = wait_code;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrist_q   <= sps_pkg::DUTY_MIN_RST;
      elbow_q   <= sps_pkg::DUTY_MIN_RST;
      grip_q    <= sps_pkg::GRIP_MIN_RST;
      valid_q   <= '0;
      total_q   <= '0;
      running_q <= 1'b0;
      stage_q   <= '0;
    end else if (push) begin
      wrist_q   <= wrist_d;
      elbow_q   <= elbow_d;
      grip_q    <= grip_d;
      valid_q   <= valid_d;
      total_q   <= total_d;
      running_q <= running_d;
      stage_q   <= stage_d;
    end
  end

  // Pose store and goal, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      goal_q <= goal_d;
      if (pose_we) begin
        pose_q[pose_widx] <= '{wrist: wrist_q, elbow: elbow_q, grip: grip_q};
      end
    end
  end

  // Output buffer valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        head_v_q <= push;
      end
    end else if (push) begin
      if (head_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        head_v_q <= 1'b1;
      end
    end
  end

  // Output buffer payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        head_q <= skid_q;
      end else if (push) begin
        head_q <= res;
      end
    end else if (push) begin
      if (head_v_q) begin
        skid_q <= res;
      end else begin
        head_q <= res;
      end
    end
  end

endmodule

// ===== test/tb_servo_pose_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_servo_pose_sequencer
// Self-checking bench for the servo pose sequencer. A short table of key
// events and ticks comes first, then random traffic under six register
// settings. Responses are checked against the table's fixed expectations
// or a bench pose predictor. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_servo_pose_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import sps_pkg::*;

  localparam int RAND_ITEMS   = 850;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 200000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sps_req_if req_if ();
  sps_rsp_if rsp_if ();

  servo_pose_sequencer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Idle rates in percent of cycles
  int tx_idle_pct = 6;
  int rx_idle_pct = 87;

  int n_err     = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_arrive  = 0;
  int n_reject  = 0;
  int n_noop    = 0;
  int cycle_cnt = 0;

  // Predictor state: limits, arm widths, pose store, playback
  logic [DUTY_W-1:0] lim_duty_min = DUTY_MIN_RST;
  logic [DUTY_W-1:0] lim_duty_max = DUTY_MAX_RST;
  logic [DUTY_W-1:0] lim_grip_min = GRIP_MIN_RST;
  logic [DUTY_W-1:0] lim_grip_max = GRIP_MAX_RST;
  logic [STEP_W-1:0] lim_step     = DUTY_STEP_RST;

  pose_t                 arm = '{DUTY_MIN_RST, DUTY_MIN_RST, GRIP_MIN_RST};
  pose_t                 goal_pose;
  pose_t                 saved_pose [POSE_SLOTS];
  logic [POSE_SLOTS-1:0] saved_ok  = '0;
  int                    saved_n   = 0;
  bit                    play_on   = 1'b0;
  int                    stage_idx = 0;
  bit                    pred_acted;

  rsp_t pose_expect_q [$];

  typedef struct {
    req_t req;
    bit   has_want;
    rsp_t want;
  } dir_step_t;

  dir_step_t dir_tbl [$];

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [DUTY_W-1:0] nudge_up(input logic [DUTY_W-1:0] v,
                                                 input logic [DUTY_W-1:0] hi);
    int s;
    s = int'(v) + int'(lim_step);
    return (s < int'(hi)) ? DUTY_W'(s) : hi;
  endfunction

  function automatic logic [DUTY_W-1:0] nudge_down(input logic [DUTY_W-1:0] v,
                                                   input logic [DUTY_W-1:0] lo);
    int s;
    s = int'(v) - int'(lim_step);
    return (s > int'(lo)) ? DUTY_W'(s) : lo;
  endfunction

  // One slew step toward g, never overshooting
  function automatic logic [DUTY_W-1:0] slew_toward(input logic [DUTY_W-1:0] v,
                                                    input logic [DUTY_W-1:0] g);
    int d;
    if (v < g) begin
      d = int'(g) - int'(v);
      return (d <= int'(lim_step)) ? g : DUTY_W'(int'(v) + int'(lim_step));
    end else if (v > g) begin
      d = int'(v) - int'(g);
      return (d <= int'(lim_step)) ? g : DUTY_W'(int'(v) - int'(lim_step));
    end
    return v;
  endfunction

  // Applies one request to the predictor state and returns the status it reports
  function automatic rsp_t predict_pose(input req_t r);
    rsp_t o;
    int   k;
    bit   ok;
    o = '0;
    pred_acted = 1'b0;
    if (r.req_type == REQ_KEY) begin
      if (r.key_pressed && !r.shift_active) begin
        pred_acted = 1'b1;
        if (r.key_value == K_WR_UP) begin
          arm.wrist = nudge_up(arm.wrist, lim_duty_max);
        end else if (r.key_value == K_WR_DN) begin
          arm.wrist = nudge_down(arm.wrist, lim_duty_min);
        end else if (r.key_value == K_EL_DN) begin
          arm.elbow = nudge_down(arm.elbow, lim_duty_min);
        end else if (r.key_value == K_EL_UP) begin
          arm.elbow = nudge_up(arm.elbow, lim_duty_max);
        end else if (r.key_value == K_GR_CLOSE) begin
          arm.grip = nudge_down(arm.grip, lim_grip_min);
        end else if (r.key_value == K_GR_OPEN) begin
          arm.grip = nudge_up(arm.grip, lim_grip_max);
        end else if (r.key_value >= K_SLOT0 && r.key_value < K_SLOT0 + POSE_SLOTS) begin
          k = int'(r.key_value - K_SLOT0);
          if (saved_n < k + 1) saved_n = k + 1;
          saved_pose[k] = arm;
          saved_ok[k]   = 1'b1;
        end else if (r.key_value == K_ENTER) begin
          // start only with two or more poses, all saved
          ok = (saved_n >= 2) && (saved_n <= POSE_SLOTS);
          for (int i = 0; i < saved_n; i++) begin
            if (!saved_ok[i]) ok = 1'b0;
          end
          if (ok) begin
            play_on     = 1'b1;
            stage_idx   = 0;
            goal_pose   = saved_pose[0];
            o.next_wait = WAIT_SHORT;
          end else begin
            play_on          = 1'b0;
            o.start_rejected = 1'b1;
            n_reject++;
          end
        end else if (r.key_value == K_ESC) begin
          play_on     = 1'b0;
          saved_n     = 0;
          saved_ok    = '0;
          o.next_wait = WAIT_NOW;
        end else begin
          pred_acted = 1'b0;
        end
      end
    end else if (play_on) begin
      pred_acted = 1'b1;
      if (arm == goal_pose) begin
        stage_idx   = (saved_n != 0) ? (stage_idx + 1) % saved_n : 0;
        goal_pose   = saved_pose[stage_idx];
        o.next_wait = WAIT_LONG;
        n_arrive++;
      end else begin
        arm.wrist   = slew_toward(arm.wrist, goal_pose.wrist);
        arm.elbow   = slew_toward(arm.elbow, goal_pose.elbow);
        arm.grip    = slew_toward(arm.grip, goal_pose.grip);
        o.next_wait = WAIT_SHORT;
      end
    end
    o.wrist_duty  = arm.wrist;
    o.elbow_duty  = arm.elbow;
    o.grip_duty   = arm.grip;
    o.playing     = play_on;
    o.stage_now   = stage_idx[1:0];
    o.saved_count = saved_n[2:0];
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic req_t key_press(input logic [KEY_W-1:0] kv);
    return req_t'{REQ_KEY, kv, 1'b1, 1'b0};
  endfunction

  // Status while stopped at stage 0
  function automatic rsp_t stopped_rsp(input int w, input int e, input int g,
                                       input int cnt, input bit rej,
                                       input logic [1:0] nw);
    return rsp_t'{DUTY_W'(w), DUTY_W'(e), DUTY_W'(g), 1'b0, 2'd0, 3'(cnt), rej, nw};
  endfunction

  function automatic void add_step(input req_t r, input bit has_want = 1'b0,
                                   input rsp_t want = '0);
    dir_tbl.push_back('{req: r, has_want: has_want, want: want});
  endfunction

  // Keys that do something, weighted toward building and playing poses
  function automatic logic [KEY_W-1:0] pick_key();
    int p;
    p = $urandom_range(99);
    if (p < 48) begin
      case ($urandom_range(5))
        0: return K_WR_UP;
        1: return K_WR_DN;
        2: return K_EL_UP;
        3: return K_EL_DN;
        4: return K_GR_OPEN;
        default: return K_GR_CLOSE;
      endcase
    end
    if (p < 76) return K_SLOT0 + KEY_W'($urandom_range(POSE_SLOTS - 1));
    if (p < 94) return K_ENTER;
    return K_ESC;
  endfunction

  // Mostly ticks and live keys; the rest releases, shifted and unknown codes
  function automatic req_t make_request();
    req_t r;
    int   p;
    r.req_type     = REQ_KEY;
    r.key_value    = KEY_W'($urandom);
    r.key_pressed  = 1'($urandom_range(1));
    r.shift_active = 1'($urandom_range(1));
    p = $urandom_range(99);
    if (p < 33) begin
      r.req_type = REQ_TICK;
    end else if (p < 78) begin
      r = key_press(pick_key());
    end else begin
      case ($urandom_range(3))
        0: begin
          r.key_value   = pick_key();
          r.key_pressed = 1'b0;
        end
        1: begin
          r.key_value    = pick_key();
          r.key_pressed  = 1'b1;
          r.shift_active = 1'b1;
        end
        2: ;
        default: r = key_press(K_SLOT0 + KEY_W'(POSE_SLOTS + $urandom_range(11)));
      endcase
    end
    return r;
  endfunction

  // One request transfer; expectation queued at the accepting edge
  task automatic send_req(input req_t r, input bit has_want, input rsp_t want);
    rsp_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pred = predict_pose(r);
    if (!pred_acted) n_noop++;
    pose_expect_q.push_back(has_want ? want : pred);
    n_sent++;
  endtask

  // Hold the sender until every response is back
  task automatic settle();
    req_if.valid <= 1'b0;
    while (pose_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk_i);
    case (idx)
      CFG_DUTY_MIN:  lim_duty_min = DUTY_W'(val);
      CFG_DUTY_MAX:  lim_duty_max = DUTY_W'(val);
      CFG_GRIP_MIN:  lim_grip_min = DUTY_W'(val);
      CFG_GRIP_MAX:  lim_grip_max = DUTY_W'(val);
      CFG_DUTY_STEP: lim_step     = STEP_W'(val);
      default: ;
    endcase
  endtask

  task automatic write_limits(input int unsigned dmin, input int unsigned dmax,
                              input int unsigned gmin, input int unsigned gmax,
                              input int unsigned step);
    write_reg(CFG_DUTY_MIN, dmin);
    write_reg(CFG_DUTY_MAX, dmax);
    write_reg(CFG_GRIP_MIN, gmin);
    write_reg(CFG_GRIP_MAX, gmax);
    write_reg(CFG_DUTY_STEP, step);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Response side: random ready and field-by-field compare
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni) rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got = rsp_if.payload;
      if (pose_expect_q.size() == 0) begin
        $error("response transfer with nothing expected");
        n_err++;
      end else begin
        want = pose_expect_q.pop_front();
        n_checked++;
        if (got.wrist_duty !== want.wrist_duty) begin
          $error("wrist_duty: expected %0d, got %0d", want.wrist_duty, got.wrist_duty);
          n_err++;
        end
        if (got.elbow_duty !== want.elbow_duty) begin
          $error("elbow_duty: expected %0d, got %0d", want.elbow_duty, got.elbow_duty);
          n_err++;
        end
        if (got.grip_duty !== want.grip_duty) begin
          $error("grip_duty: expected %0d, got %0d", want.grip_duty, got.grip_duty);
          n_err++;
        end
        if (got.playing !== want.playing) begin
          $error("playing: expected %0d, got %0d", want.playing, got.playing);
          n_err++;
        end
        if (got.stage_now !== want.stage_now) begin
          $error("stage_now: expected %0d, got %0d", want.stage_now, got.stage_now);
          n_err++;
        end
        if (got.saved_count !== want.saved_count) begin
          $error("saved_count: expected %0d, got %0d", want.saved_count, got.saved_count);
          n_err++;
        end
        if (got.start_rejected !== want.start_rejected) begin
          $error("start_rejected: expected %0d, got %0d",
                 want.start_rejected, got.start_rejected);
          n_err++;
        end
        if (got.next_wait !== want.next_wait) begin
          $error("next_wait: expected %0d, got %0d", want.next_wait, got.next_wait);
          n_err++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int n_eff;
    int phase_end;
    int n_directed;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    n_eff          = 0;

    // Directed table: nudges and clamps, ignored events, refused starts,
    // then a short playback with a save while running
    add_step(req_t'{REQ_TICK, 16'hFFFF, 1'b1, 1'b1}, 1'b1,
             stopped_rsp(200, 200, 200, 0, 1'b0, WAIT_NONE));
    add_step(key_press(K_WR_DN), 1'b1, stopped_rsp(200, 200, 200, 0, 1'b0, WAIT_NONE));
    add_step(key_press(K_WR_UP), 1'b1, stopped_rsp(250, 200, 200, 0, 1'b0, WAIT_NONE));
    add_step(key_press(K_EL_UP), 1'b1, stopped_rsp(250, 250, 200, 0, 1'b0, WAIT_NONE));
    add_step(key_press(K_EL_DN), 1'b1, stopped_rsp(250, 200, 200, 0, 1'b0, WAIT_NONE));
    add_step(key_press(K_GR_OPEN), 1'b1, stopped_rsp(250, 200, 250, 0, 1'b0, WAIT_NONE));
    add_step(key_press(K_GR_CLOSE), 1'b1, stopped_rsp(250, 200, 200, 0, 1'b0, WAIT_NONE));
    add_step(req_t'{REQ_KEY, K_WR_UP, 1'b0, 1'b0}, 1'b1,
             stopped_rsp(250, 200, 200, 0, 1'b0, WAIT_NONE));
    add_step(req_t'{REQ_KEY, K_WR_UP, 1'b1, 1'b1}, 1'b1,
             stopped_rsp(250, 200, 200, 0, 1'b0, WAIT_NONE));
    add_step(key_press(16'h0000), 1'b1, stopped_rsp(250, 200, 200, 0, 1'b0, WAIT_NONE));
    add_step(key_press(K_ENTER), 1'b1, stopped_rsp(250, 200, 200, 0, 1'b1, WAIT_NONE));
    add_step(key_press(K_SLOT0), 1'b1, stopped_rsp(250, 200, 200, 1, 1'b0, WAIT_NONE));
    add_step(key_press(K_ENTER), 1'b1, stopped_rsp(250, 200, 200, 1, 1'b1, WAIT_NONE));
    add_step(key_press(K_SLOT0 + 16'd3), 1'b1,
             stopped_rsp(250, 200, 200, 4, 1'b0, WAIT_NONE));
    add_step(key_press(K_ENTER), 1'b1, stopped_rsp(250, 200, 200, 4, 1'b1, WAIT_NONE));
    add_step(key_press(K_SLOT0 + KEY_W'(POSE_SLOTS)), 1'b1,
             stopped_rsp(250, 200, 200, 4, 1'b0, WAIT_NONE));
    add_step(key_press(K_ESC), 1'b1, stopped_rsp(250, 200, 200, 0, 1'b0, WAIT_NOW));
    add_step(key_press(K_GR_OPEN));
    add_step(key_press(K_SLOT0 + 16'd1));
    add_step(key_press(K_GR_CLOSE));
    add_step(key_press(K_SLOT0));
    add_step(key_press(K_ENTER));
    add_step(req_t'{REQ_TICK, 16'h0000, 1'b0, 1'b0});
    add_step(req_t'{REQ_TICK, 16'h0000, 1'b0, 1'b0});
    add_step(key_press(K_SLOT0 + 16'd2));
    add_step(req_t'{REQ_TICK, 16'h0000, 1'b0, 1'b0});
    add_step(key_press(K_ESC));
    n_directed = dir_tbl.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i]) send_req(dir_tbl[i].req, dir_tbl[i].has_want, dir_tbl[i].want);
    settle();

    // Random traffic, one register setting per phase
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_limits(0, 20000, 0, 20000, 1000);
        1: write_limits(300, 700, 100, 1200, 1);
        2: write_limits(800, 300, 900, 100, 37);        // inverted limits
        3: write_limits(20000, 20000, 0, 0, 0);         // step of zero
        4: write_limits($urandom_range(20000), $urandom_range(20000),
                        $urandom_range(20000), $urandom_range(20000),
                        $urandom_range(1000, 1));
        default: write_limits(DUTY_MIN_RST, DUTY_MAX_RST, GRIP_MIN_RST, GRIP_MAX_RST,
                              DUTY_STEP_RST);
      endcase
      phase_end = (phase + 1) * RAND_ITEMS / 6;
      while (n_eff < phase_end) begin
        if (n_eff < RAND_ITEMS / 3) begin
          tx_idle_pct = 6;
          rx_idle_pct = 87;
        end else if (n_eff < 2 * RAND_ITEMS / 3) begin
          tx_idle_pct = 87;
          rx_idle_pct = 6;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        send_req(make_request(), 1'b0, '0);
        n_eff++;
      end
      settle();
    end

    if (pose_expect_q.size() != 0) begin
      $error("%0d responses never arrived", pose_expect_q.size());
      n_err++;
    end
    $display("Sent %0d requests (%0d from the table, %0d left state alone) under six",
             n_sent, n_directed, n_noop);
    $display("register settings; %0d checked. Playback reached %0d poses; %0d starts refused.",
             n_checked, n_arrive, n_reject);
    if (n_err == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sps_pkg.sv
hdl/sps_if.sv
hdl/servo_pose_sequencer.sv
test/tb_servo_pose_sequencer.sv
